/* sv/lzs_pkg.sv */
package lzs_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Offsets in the format are at most 11 bits wide.
    localparam int OFF_W = 11;

    // Results beyond this count for one compressed byte are dropped.
    localparam int RES_W = 5;
    localparam logic [RES_W-1:0] MAX_RESULTS = 5'd30;

    // One result handed from the parser to the output stage.
    typedef struct packed {
        logic       push;
        logic       flush;
        logic [7:0] data;
        logic [1:0] kind;
    } emit_t;

endpackage

/* sv/lzs_in_if.sv */
interface lzs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] compressed_byte;

    modport source (output valid, output compressed_byte, input ready);
    modport sink (input valid, input compressed_byte, output ready);
endinterface

/* sv/lzs_out_if.sv */
interface lzs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last_of_run;

    modport source (output valid, output out_byte, output kind, output last_of_run,
                    input ready);
    modport sink (input valid, input out_byte, input kind, input last_of_run,
                  output ready);
endinterface

/* sv/lzs_stream_decompressor.sv */
// Each compressed byte is taken from the input and then parsed one bit per cycle,
// stalling while a result waits for a free output slot; the next byte is taken
// in the flush state after its last bit, once the slot is free. Each copied byte
// adds a read of the history memory and the write-back of the byte it returns.
// The last result of a byte leaves the pending slot for the output register in the flush state.
// Reset clears all control state asynchronously; the history memory is not cleared.
module lzs_stream_decompressor #(
    parameter int HISTORY_DEPTH = 2048
) (
    input  logic             clk,
    input  logic             rst_n,
    lzs_in_if.sink           comp_ch,
    lzs_out_if.source        data_ch
);

    import lzs_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);

    emit_t         emit;
    logic          slot_free;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    lzs_parser #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (comp_ch.valid),
        .in_data   (comp_ch.compressed_byte),
        .in_ready  (comp_ch.ready),
        .slot_free (slot_free),
        .emit      (emit),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    lzs_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lzs_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .slot_free (slot_free),
        .out_ready (data_ch.ready),
        .out_valid (data_ch.valid),
        .out_byte  (data_ch.out_byte),
        .out_kind  (data_ch.kind),
        .out_last  (data_ch.last_of_run)
    );

    // The history is never read and written in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n) !(ram_we && ram_re))
        else $error("history read and write collide");

    // A copy read is always followed by its write-back cycle, never another read.
    assert property (@(posedge clk) disable iff (!rst_n) ram_re |=> !ram_re)
        else $error("back-to-back history reads");

    // End and error results carry a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (data_ch.valid && data_ch.kind != KIND_DATA) |-> data_ch.out_byte == 8'd0)
        else $error("non-data result with nonzero byte");

    // Nothing is pushed while the parser waits for a new compressed byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (comp_ch.ready && !emit.flush) |-> !emit.push)
        else $error("result pushed while idle");

endmodule

/* sv/lzs_ram.sv */
module lzs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/lzs_out_buf.sv */
module lzs_out_buf (
    input  logic          clk,
    input  logic          rst_n,
    input  lzs_pkg::emit_t emit,
    output logic          slot_free,
    input  logic          out_ready,
    output logic          out_valid,
    output logic [7:0]    out_byte,
    output logic [1:0]    out_kind,
    output logic          out_last
);

    import lzs_pkg::*;

    // The newest result waits in the pending slot until either another result
    // follows (it leaves as not last) or the byte ends (it leaves as last).
    logic       pend_valid_reg, pend_valid_next;
    logic [7:0] pend_byte_reg, pend_byte_next;
    logic [1:0] pend_kind_reg, pend_kind_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic [1:0] out_kind_reg, out_kind_next;
    logic       out_last_reg, out_last_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign slot_free = !pend_valid_reg || out_free;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        pend_kind_next  = pend_kind_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_byte_next   = out_byte_reg;
        out_kind_next   = out_kind_reg;
        out_last_next   = out_last_reg;
        priority if (emit.push && slot_free)
        begin
            pend_valid_next = 1'b1;
            pend_byte_next  = emit.data;
            pend_kind_next  = emit.kind;
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = pend_byte_reg;
                out_kind_next  = pend_kind_reg;
                out_last_next  = 1'b0;
            end
        end
        else if (emit.flush && pend_valid_reg && out_free)
        begin
            pend_valid_next = 1'b0;
            out_valid_next  = 1'b1;
            out_byte_next   = pend_byte_reg;
            out_kind_next   = pend_kind_reg;
            out_last_next   = 1'b1;
        end
        else
        begin
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_byte_reg <= pend_byte_next;
        pend_kind_reg <= pend_kind_next;
        out_byte_reg  <= out_byte_next;
        out_kind_reg  <= out_kind_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_kind  = out_kind_reg;
    assign out_last  = out_last_reg;

endmodule

/* sv/lzs_parser.sv */
module lzs_parser #(
    parameter int HISTORY_DEPTH = 2048
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [7:0]                       in_data,
    output logic                             in_ready,
    input  logic                             slot_free,
    output lzs_pkg::emit_t                   emit,
    output logic                             ram_we,
    output logic [$clog2(HISTORY_DEPTH)-1:0] ram_waddr,
    output logic [7:0]                       ram_wdata,
    output logic                             ram_re,
    output logic [$clog2(HISTORY_DEPTH)-1:0] ram_raddr,
    input  logic [7:0]                       ram_rdata
);

    import lzs_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam logic [AW:0] PROD_FULL = (AW+1)'(HISTORY_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BIT   = 3'd1;
    localparam logic [2:0] S_CRD   = 3'd2;
    localparam logic [2:0] S_CWR   = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    localparam logic [2:0] P_FLAG  = 3'd0;
    localparam logic [2:0] P_LIT   = 3'd1;
    localparam logic [2:0] P_SIZE  = 3'd2;
    localparam logic [2:0] P_OFF7  = 3'd3;
    localparam logic [2:0] P_OFF11 = 3'd4;
    localparam logic [2:0] P_LEN2  = 3'd5;
    localparam logic [2:0] P_LEN4  = 3'd6;
    localparam logic [2:0] P_EXT   = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [7:0]       sh_reg, sh_next;
    logic [3:0]       left_reg, left_next;
    logic [2:0]       phase_reg, phase_next;
    logic [10:0]      acc_reg, acc_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic [AW-1:0]    wp_reg, wp_next;
    logic [AW:0]      prod_reg, prod_next;
    logic [3:0]       copy_reg, copy_next;
    logic [RES_W-1:0] nres_reg, nres_next;

    // Decode of the current bit against the parse phase.
    logic             cur_bit;
    logic [10:0]      acc_n;
    logic [3:0]       cnt_n;
    logic [2:0]       dec_phase;
    logic [10:0]      dec_acc;
    logic [3:0]       dec_cnt;
    logic [OFF_W-1:0] dec_off;
    logic             dec_lit;
    logic             dec_end;
    logic             dec_err;
    logic             dec_copy;
    logic [3:0]       dec_count;
    logic             bad_off;
    logic             can_emit;
    logic             emit_any;
    logic [AW:0]      prod_inc;

    assign cur_bit  = sh_reg[7];
    assign acc_n    = {acc_reg[9:0], cur_bit};
    assign cnt_n    = cnt_reg + 4'd1;
    assign bad_off  = (acc_n == '0) || ((AW+1)'(acc_n) > prod_reg);
    assign can_emit = nres_reg < MAX_RESULTS;
    assign prod_inc = (prod_reg != PROD_FULL) ? prod_reg + (AW+1)'(1) : prod_reg;
    assign emit_any = dec_lit || dec_end || dec_err;

    always_comb
    begin
        dec_phase = phase_reg;
        dec_acc   = acc_n;
        dec_cnt   = cnt_n;
        dec_off   = off_reg;
        dec_lit   = 1'b0;
        dec_end   = 1'b0;
        dec_err   = 1'b0;
        dec_copy  = 1'b0;
        dec_count = 4'd0;
        unique case (phase_reg)
            P_FLAG:
            begin
                dec_acc   = '0;
                dec_cnt   = '0;
                dec_phase = cur_bit ? P_SIZE : P_LIT;
            end
            P_LIT:
            begin
                if (cnt_n >= 4'd8)
                begin
                    dec_lit   = 1'b1;
                    dec_acc   = '0;
                    dec_cnt   = '0;
                    dec_phase = P_FLAG;
                end
            end
            P_SIZE:
            begin
                dec_acc   = '0;
                dec_cnt   = '0;
                dec_phase = cur_bit ? P_OFF7 : P_OFF11;
            end
            P_OFF7, P_OFF11:
            begin
                if ((phase_reg == P_OFF7 && cnt_n >= 4'd7) || cnt_n >= 4'd11)
                begin
                    if (phase_reg == P_OFF7 && acc_n == '0)
                    begin
                        dec_end = 1'b1;
                    end
                    else
                    begin
                        dec_err   = bad_off;
                        dec_off   = bad_off ? '0 : acc_n;
                        dec_acc   = '0;
                        dec_cnt   = '0;
                        dec_phase = P_LEN2;
                    end
                end
            end
            P_LEN2:
            begin
                if (cnt_n >= 4'd2)
                begin
                    dec_acc = '0;
                    dec_cnt = '0;
                    if (acc_n[1:0] == 2'd3)
                    begin
                        dec_phase = P_LEN4;
                    end
                    else
                    begin
                        dec_copy  = 1'b1;
                        dec_count = {2'b00, acc_n[1:0]} + 4'd2;
                        dec_phase = P_FLAG;
                    end
                end
            end
            P_LEN4:
            begin
                if (cnt_n >= 4'd2)
                begin
                    dec_acc  = '0;
                    dec_cnt  = '0;
                    dec_copy = 1'b1;
                    if (acc_n[1:0] == 2'd3)
                    begin
                        dec_count = 4'd8;
                        dec_phase = P_EXT;
                    end
                    else
                    begin
                        dec_count = {2'b00, acc_n[1:0]} + 4'd5;
                        dec_phase = P_FLAG;
                    end
                end
            end
            P_EXT:
            begin
                if (cnt_n >= 4'd4)
                begin
                    dec_acc   = '0;
                    dec_cnt   = '0;
                    dec_copy  = 1'b1;
                    dec_count = acc_n[3:0];
                    if (acc_n[3:0] != 4'd15)
                    begin
                        dec_phase = P_FLAG;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        sh_next    = sh_reg;
        left_next  = left_reg;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        off_next   = off_reg;
        wp_next    = wp_reg;
        prod_next  = prod_reg;
        copy_next  = copy_reg;
        nres_next  = nres_reg;
        in_ready   = 1'b0;
        emit       = '0;
        ram_we     = 1'b0;
        ram_waddr  = wp_reg;
        ram_wdata  = acc_n[7:0];
        ram_re     = 1'b0;
        ram_raddr  = wp_reg - AW'(off_reg);
        unique case (state_reg)
            S_IDLE, S_FLUSH:
            begin
                // The last result of the previous byte leaves as the next is taken.
                emit.flush = (state_reg == S_FLUSH);
                if (state_reg == S_IDLE || slot_free)
                begin
                    in_ready   = 1'b1;
                    state_next = S_IDLE;
                    if (in_valid)
                    begin
                        sh_next    = in_data;
                        left_next  = 4'd8;
                        nres_next  = '0;
                        state_next = S_BIT;
                    end
                end
            end
            S_BIT:
            begin
                if (!(emit_any && can_emit && !slot_free))
                begin
                    emit.push  = emit_any && can_emit;
                    emit.data  = dec_lit ? acc_n[7:0] : 8'd0;
                    emit.kind  = dec_lit ? KIND_DATA : (dec_end ? KIND_END : KIND_ERROR);
                    if (emit_any && can_emit)
                    begin
                        nres_next = nres_reg + RES_W'(1);
                    end
                    sh_next    = {sh_reg[6:0], 1'b0};
                    left_next  = left_reg - 4'd1;
                    phase_next = dec_phase;
                    acc_next   = dec_acc;
                    cnt_next   = dec_cnt;
                    off_next   = dec_off;
                    if (dec_lit)
                    begin
                        ram_we    = 1'b1;
                        wp_next   = wp_reg + AW'(1);
                        prod_next = prod_inc;
                    end
                    priority if (dec_end)
                    begin
                        // End marker: drop the rest of the byte and restart.
                        wp_next    = '0;
                        prod_next  = '0;
                        phase_next = P_FLAG;
                        acc_next   = '0;
                        cnt_next   = '0;
                        off_next   = '0;
                        state_next = S_FLUSH;
                    end
                    else if (dec_copy && off_reg != '0 && dec_count != 4'd0)
                    begin
                        copy_next  = dec_count;
                        state_next = S_CRD;
                    end
                    else if (left_reg == 4'd1)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_BIT;
                    end
                end
            end
            S_CRD:
            begin
                ram_re     = 1'b1;
                state_next = S_CWR;
            end
            S_CWR:
            begin
                // Each copied byte is written before the next read is issued, so
                // an overlapping copy always sees the byte it just produced.
                if (!(can_emit && !slot_free))
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    wp_next   = wp_reg + AW'(1);
                    prod_next = prod_inc;
                    emit.push = can_emit;
                    emit.data = ram_rdata;
                    emit.kind = KIND_DATA;
                    if (can_emit)
                    begin
                        nres_next = nres_reg + RES_W'(1);
                    end
                    copy_next = copy_reg - 4'd1;
                    if (copy_reg == 4'd1)
                    begin
                        state_next = (left_reg == 4'd0) ? S_FLUSH : S_BIT;
                    end
                    else
                    begin
                        state_next = S_CRD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            left_reg  <= '0;
            phase_reg <= P_FLAG;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            off_reg   <= '0;
            wp_reg    <= '0;
            prod_reg  <= '0;
            copy_reg  <= '0;
            nres_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            left_reg  <= left_next;
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            off_reg   <= off_next;
            wp_reg    <= wp_next;
            prod_reg  <= prod_next;
            copy_reg  <= copy_next;
            nres_reg  <= nres_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
    end

endmodule

/* tb/lzs_stream_decompressor_tb.sv */
`timescale 1ns / 1ps

module lzs_stream_decompressor_tb;
    import lzs_pkg::*;

    localparam int HIST_DEPTH    = 2048;
    localparam int RANDOM_BYTES  = 370;
    localparam int REPORT_LIMIT  = 10;
    localparam int SETTLE_CYCLES = 200;

    typedef enum logic [3:0] {
        TOK_FLAG,
        TOK_LITERAL,
        TOK_SIZE,
        TOK_OFF7,
        TOK_OFF11,
        TOK_LEN2,
        TOK_LEN4,
        TOK_EXT
    } token_step_t;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
    } decoded_t;

    class lzs_decode_board;
        logic [7:0]  hist [HIST_DEPTH];
        logic [10:0] wr_ptr;
        int          out_total;
        token_step_t step;
        logic [10:0] acc;
        logic [3:0]  acc_bits;
        logic [10:0] copy_dist;
        decoded_t    awaited [$];
        decoded_t    burst [$];
        int          bytes_in;
        int          checked;
        int          data_cnt;
        int          end_cnt;
        int          err_cnt;
        int          failures;

        function new();
            foreach (hist[i]) hist[i] = 8'h00;
            restart();
            bytes_in = 0;
            checked  = 0;
            data_cnt = 0;
            end_cnt  = 0;
            err_cnt  = 0;
            failures = 0;
        endfunction

        function void restart();
            wr_ptr    = '0;
            out_total = 0;
            step      = TOK_FLAG;
            acc       = '0;
            acc_bits  = '0;
            copy_dist = '0;
        endfunction

        function void clear_acc();
            acc      = '0;
            acc_bits = '0;
        endfunction

        function void push_result(logic [7:0] data, logic [1:0] kind);
            decoded_t r;
            if (burst.size() >= int'(MAX_RESULTS))
                return;
            r.data = data;
            r.kind = kind;
            r.last = 1'b0;
            burst.insert(burst.size(), r);
        endfunction

        function void write_out(logic [7:0] b);
            hist[wr_ptr] = b;
            wr_ptr = wr_ptr + 11'd1;
            if (out_total < HIST_DEPTH)
                out_total++;
            push_result(b, KIND_DATA);
        endfunction

        // A cleared distance marks a match whose offset was rejected.
        function void copy_run(int count);
            logic [10:0] src;
            if (copy_dist == '0)
                return;
            for (int k = 0; k < count; k++)
            begin
                src = wr_ptr - copy_dist;
                write_out(hist[src]);
            end
        endfunction

        function void offset_end();
            if (acc == '0 || acc > out_total)
            begin
                copy_dist = '0;
                push_result(8'h00, KIND_ERROR);
            end
            else
                copy_dist = acc;
            clear_acc();
            step = TOK_LEN2;
        endfunction

        function void take_compressed(logic [7:0] b);
            logic       cur;
            logic       done;
            logic [3:0] code;
            burst.delete();
            bytes_in++;
            for (int i = 7; i >= 0; i--)
            begin
                cur = b[i];
                done = 1'b0;
                acc = {acc[9:0], cur};
                acc_bits = acc_bits + 4'd1;
                case (step)
                    TOK_FLAG:
                    begin
                        clear_acc();
                        step = cur ? TOK_SIZE : TOK_LITERAL;
                    end
                    TOK_LITERAL:
                        if (acc_bits >= 4'd8)
                        begin
                            write_out(acc[7:0]);
                            clear_acc();
                            step = TOK_FLAG;
                        end
                    TOK_SIZE:
                    begin
                        clear_acc();
                        step = cur ? TOK_OFF7 : TOK_OFF11;
                    end
                    TOK_OFF7:
                        if (acc_bits >= 4'd7)
                        begin
                            if (acc == '0)
                            begin
                                push_result(8'h00, KIND_END);
                                done = 1'b1;
                            end
                            else
                                offset_end();
                        end
                    TOK_OFF11:
                        if (acc_bits >= 4'd11)
                            offset_end();
                    TOK_LEN2:
                        if (acc_bits >= 4'd2)
                        begin
                            code = {2'b00, acc[1:0]};
                            clear_acc();
                            if (code == 4'd3)
                                step = TOK_LEN4;
                            else
                            begin
                                copy_run(int'(code) + 2);
                                step = TOK_FLAG;
                            end
                        end
                    TOK_LEN4:
                        if (acc_bits >= 4'd2)
                        begin
                            code = {2'b00, acc[1:0]};
                            clear_acc();
                            if (code == 4'd3)
                            begin
                                copy_run(8);
                                step = TOK_EXT;
                            end
                            else
                            begin
                                copy_run(int'(code) + 5);
                                step = TOK_FLAG;
                            end
                        end
                    TOK_EXT:
                        if (acc_bits >= 4'd4)
                        begin
                            code = acc[3:0];
                            clear_acc();
                            copy_run(int'(code));
                            if (code != 4'hF)
                                step = TOK_FLAG;
                        end
                    default:
                    begin
                        clear_acc();
                        step = TOK_FLAG;
                    end
                endcase
                // The end marker drops whatever is left of the byte.
                if (done)
                begin
                    restart();
                    break;
                end
            end
            if (burst.size() > 0)
                burst[burst.size() - 1].last = 1'b1;
            foreach (burst[j]) awaited.insert(awaited.size(), burst[j]);
        endfunction

        function void check_output(logic [7:0] data, logic [1:0] kind, logic last);
            decoded_t want;
            if (awaited.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result: data %02h kind %0d last %0b",
                             data, kind, last);
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (data !== want.data || kind !== want.kind || last !== want.last)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("result %0d: expected %02h/%0d/%0b, got %02h/%0d/%0b",
                             checked, want.data, want.kind, want.last, data, kind, last);
            end
            case (want.kind)
                KIND_DATA: data_cnt++;
                KIND_END:  end_cnt++;
                default:   err_cnt++;
            endcase
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lzs_in_if  comp_ch ();
    lzs_out_if data_ch ();

    lzs_stream_decompressor u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .comp_ch (comp_ch),
        .data_ch (data_ch)
    );

    always #4 clk = ~clk;

    lzs_decode_board board;
    bit              bit_q [$];
    int              gen_count;
    bit              in_burst;
    bit              out_burst;

    function automatic int draw_wait(ref bit burst_mode);
        if ($urandom_range(0, 19) == 0)
            burst_mode = !burst_mode;
        return burst_mode ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(2, 8);
        if (r < 92)
            return $urandom_range(9, 40);
        return $urandom_range(41, 250);
    endfunction

    // Valid stays high across back-to-back beats, so it is only lowered for a gap.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_wait(in_burst);
        if (gap > 0)
        begin
            comp_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        comp_ch.valid <= 1'b1;
        comp_ch.compressed_byte <= b;
        @(negedge clk);
        while (comp_ch.ready !== 1'b1)
            @(negedge clk);
        @(posedge clk);
        board.take_compressed(b);
    endtask

    task automatic put_bits(input logic [15:0] value, input int width);
        logic [7:0] b;
        b = 8'h00;
        for (int i = width - 1; i >= 0; i--)
            bit_q.insert(bit_q.size(), value[i]);
        while (bit_q.size() >= 8)
        begin
            for (int i = 0; i < 8; i++)
                b = {b[6:0], bit_q.pop_front()};
            send_byte(b);
        end
    endtask

    task automatic put_length(input int len);
        int rest;
        case (len)
            2: put_bits(16'b00, 2);
            3: put_bits(16'b01, 2);
            4: put_bits(16'b10, 2);
            5: put_bits(16'b1100, 4);
            6: put_bits(16'b1101, 4);
            7: put_bits(16'b1110, 4);
            default:
            begin
                put_bits(16'hF, 4);
                rest = len - 8;
                while (rest >= 15)
                begin
                    put_bits(16'hF, 4);
                    rest -= 15;
                end
                put_bits(rest[15:0], 4);
            end
        endcase
    endtask

    task automatic tok_literal(input logic [7:0] b);
        put_bits({7'd0, 1'b0, b}, 9);
        if (gen_count < HIST_DEPTH)
            gen_count++;
    endtask

    task automatic tok_match(input bit short_form, input int off, input int len);
        if (short_form)
            put_bits({7'd0, 2'b11, off[6:0]}, 9);
        else
            put_bits({3'd0, 2'b10, off[10:0]}, 13);
        put_length(len);
        if (off != 0 && off <= gen_count)
            gen_count = (gen_count + len > HIST_DEPTH) ? HIST_DEPTH : gen_count + len;
    endtask

    // The rest of the byte after the marker is ignored, so fill it with junk.
    task automatic tok_end();
        put_bits(16'b110000000, 9);
        if (bit_q.size() > 0)
            put_bits(16'($urandom_range(0, 255)), 8 - bit_q.size());
        gen_count = 0;
    endtask

    // Zero bytes walk the parser out of any token and into the literal loop;
    // stop once a byte boundary lands on a token start.
    task automatic resync();
        int tries;
        tries = 0;
        if (bit_q.size() > 0)
            put_bits(16'h0, 8 - bit_q.size());
        while (board.step != TOK_FLAG && tries < 40)
        begin
            send_byte(8'h00);
            tries++;
        end
        gen_count = board.out_total;
    endtask

    initial
    begin : stimulus
        int first_random;
        int pick;
        int lim;
        bit quiet;
        board = new();
        comp_ch.valid <= 1'b0;
        comp_ch.compressed_byte <= 8'h00;
        gen_count = 0;
        in_burst = 1'b0;
        out_burst = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A rejected offset while nothing is in the history, one beyond the history, literal
        // extremes, an overlapping copy, every length code and extension nibbles of 0 and 15.
        tok_match(1'b0, 0, 2);
        tok_literal(8'h00);
        tok_literal(8'hFF);
        tok_literal(8'h5A);
        tok_match(1'b1, 100, 3);
        tok_match(1'b1, 1, 2);
        tok_match(1'b1, 3, 3);
        tok_match(1'b0, 2, 4);
        tok_match(1'b1, 5, 5);
        tok_match(1'b0, 7, 6);
        tok_match(1'b1, 1, 7);
        tok_match(1'b1, 2, 8);
        tok_match(1'b0, 4, 38);
        tok_end();

        // The first half sends no end marker, so the history is not reset.
        first_random = board.bytes_in;
        while (board.bytes_in < first_random + RANDOM_BYTES)
        begin
            quiet = (board.bytes_in - first_random) < RANDOM_BYTES / 2;
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                put_bits(16'($urandom), $urandom_range(1, 16));
                resync();
            end
            else if (pick < 6 && !quiet)
                tok_end();
            else if (pick < 10)
            begin
                if (gen_count < 127 && $urandom_range(0, 1))
                    tok_match(1'b1, $urandom_range(gen_count + 1, 127), pick_length());
                else if (gen_count < 2047 && $urandom_range(0, 1))
                    tok_match(1'b0, $urandom_range(gen_count + 1, 2047), pick_length());
                else
                    tok_match(1'b0, 0, pick_length());
            end
            else if (pick < 50 || gen_count == 0)
                tok_literal(8'($urandom_range(0, 255)));
            else if ($urandom_range(0, 1))
            begin
                lim = (gen_count < 127) ? gen_count : 127;
                tok_match(1'b1, $urandom_range(1, lim), pick_length());
            end
            else
            begin
                lim = (gen_count < 2047) ? gen_count : 2047;
                tok_match(1'b0, $urandom_range(1, lim), pick_length());
            end
        end
        if (bit_q.size() > 0)
            put_bits(16'h0, 8 - bit_q.size());
        comp_ch.valid <= 1'b0;

        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Fed %0d bytes, checked %0d results (%0d data, %0d end, %0d error).",
                 board.bytes_in, board.checked, board.data_cnt, board.end_cnt,
                 board.err_cnt);
        $display("Mismatched or unexpected results: %0d, still outstanding: %0d.",
                 board.failures, board.awaited.size());
        if (board.failures == 0 && board.awaited.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : drain_results
        int         gap;
        logic [7:0] got_byte;
        logic [1:0] got_kind;
        logic       got_last;
        data_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = draw_wait(out_burst);
            if (gap > 0)
            begin
                data_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            data_ch.ready <= 1'b1;
            @(negedge clk);
            while (data_ch.valid !== 1'b1)
                @(negedge clk);
            got_byte = data_ch.out_byte;
            got_kind = data_ch.kind;
            got_last = data_ch.last_of_run;
            @(posedge clk);
            board.check_output(got_byte, got_kind, got_last);
        end
    end

    initial
    begin : watchdog
        #10ms;
        $display("Run timed out with %0d results outstanding.", board.awaited.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
